// ===== rtl/gtp_pkg.sv =====
// Shared types, constants and helpers for the two-walker grid collector.
// Used by gtp_merge, gtp_core and grid_two_path_max_collect_top; no dependencies.
package gtp_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int SIDE_W     = 7;                   // holds 0..MAX_SIDE
    localparam int IDX_W      = $clog2(MAX_SIDE);    // row index inside the grid
    localparam int CELL_AW    = 2 * IDX_W;           // cell store address
    localparam int LOAD_W     = CELL_AW + 1;         // count up to MAX_SIDE squared
    localparam int SCORE_AW   = CELL_AW + 1;         // layer bit plus row pair
    localparam int CHERRY_W   = 8;
    localparam int SCORE_W    = 17;
    localparam int TOTAL_W    = 16;
    localparam int CH_SUM_W   = CHERRY_W + 1;        // two cells added
    localparam int T_W        = SIDE_W;              // anti-diagonal index, up to 2*MAX_SIDE-2

    // One stored grid cell
    typedef struct packed {
        logic                blk;
        logic [CHERRY_W-1:0] ch;
    } t_cell;

    // One stored score: valid flag plus value
    typedef struct packed {
        logic               vld;
        logic [SCORE_W-1:0] val;
    } t_score;

    // Control for the shared compare unit
    typedef struct packed {
        logic clear;    // start a new maximum
        logic use_cand; // candidate lies inside the grid
    } t_merge_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_RUN,
        S_DONE
    } t_state;

    // Clamp the side register into 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIDE_W'(1);
        end else if (s > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

// ===== rtl/grid_two_path_max_collect_top.sv =====
// Loading takes N*N cell beats; o_valid rises once the solve that follows the last beat ends.
// Throughput: one cell beat per cycle while loading; the solve loop, which steps each
// row pair through one score read port and one compare unit, keeps busy high until o_valid.
// The result is shown for one cycle; the receiver cannot stall it.
// Reset (synchronous, i_rst_n low): side 1, load count 0, sequencer idle; stores keep data.
// Top level: side register, load counter, solver core. Depends on gtp_pkg, gtp_core.
module grid_two_path_max_collect_top import gtp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_blocked,
    input  logic [CHERRY_W-1:0]  i_cherries,
    output logic                 o_valid,
    output logic [TOTAL_W-1:0]   o_total_collected,
    output logic                 o_path_found
);

    logic [SIDE_W-1:0] r_side;
    logic [LOAD_W-1:0] r_load_cnt;
    logic [SIDE_W-1:0] w_n;
    logic [LOAD_W-1:0] w_total;
    logic [LOAD_W-1:0] w_cnt_inc;
    logic              w_accept;
    logic              w_last_beat;
    t_cell             w_cell;

    assign w_n         = eff_side(r_side);
    assign w_total     = LOAD_W'(w_n) * LOAD_W'(w_n);
    assign w_accept    = start && !busy;
    assign w_cnt_inc   = r_load_cnt + LOAD_W'(1);
    assign w_last_beat = (w_cnt_inc >= w_total);
    assign w_cell      = '{blk: i_blocked, ch: i_cherries};

    // Side register and load counter; a side write restarts the grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SIDE_W'(1);
            r_load_cnt <= '0;
        end else if (i_cfg_we) begin
            r_side     <= i_cfg_data;
            r_load_cnt <= '0;
        end else if (w_accept) begin
            r_load_cnt <= w_last_beat ? '0 : w_cnt_inc;
        end
    end

    gtp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_we   (w_accept),
        .i_load_addr (r_load_cnt[CELL_AW-1:0]),
        .i_load_data (w_cell),
        .i_go        (w_accept && w_last_beat),
        .i_side      (w_n),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_total     (o_total_collected),
        .o_found     (o_path_found)
    );

endmodule

// ===== rtl/gtp_merge.sv =====
// Shared compare unit: folds one candidate score into a running maximum.
// Depends on gtp_pkg.
module gtp_merge import gtp_pkg::*; (
    input  t_merge_ctl i_ctl,
    input  t_score     i_acc,
    input  t_score     i_cand,
    output t_score     o_acc
);

    t_score w_base;

    // Drop the old maximum at the first candidate of a cell
    always_comb begin
        w_base = i_ctl.clear ? '0 : i_acc;
    end

    // Keep the larger of running maximum and a valid in-grid candidate
    always_comb begin
        o_acc = w_base;
        if (i_ctl.use_cand && i_cand.vld &&
            (!w_base.vld || (i_cand.val > w_base.val))) begin
            o_acc = i_cand;
        end
    end

endmodule

// ===== rtl/gtp_core.sv =====
// Solver sequencer: cell store, two-layer score store and the per-cell loop.
// Each row pair steps through the phases of r_phase around one shared compare unit.
// Depends on gtp_pkg and gtp_merge.
module gtp_core import gtp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_we,
    input  logic [CELL_AW-1:0]  i_load_addr,
    input  t_cell               i_load_data,
    input  logic                i_go,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_busy,
    output logic                o_valid,
    output logic [TOTAL_W-1:0]  o_total,
    output logic                o_found
);

    t_cell  mem_cell  [2**CELL_AW];
    t_score mem_score [2**SCORE_AW];

    t_state r_state, n_state;
    logic [T_W-1:0]   r_t, n_t;
    logic [IDX_W-1:0] r_r1, n_r1;
    logic [IDX_W-1:0] r_r2, n_r2;
    logic [1:0]       r_phase;
    t_score           r_acc;
    t_score           r_top;
    logic [CH_SUM_W-1:0] r_ch;
    logic             r_pass;
    t_cell            r_cell_a, r_cell_b;
    t_score           r_rd_score;

    logic [T_W-1:0]   w_last;
    logic             w_end_r2, w_end_r1, w_end_all;

    // issue side
    logic [T_W-1:0]   iss_t;
    logic [IDX_W-1:0] iss_r1, iss_r2;
    logic [1:0]       iss_k;
    logic             iss_cells, iss_score;
    logic             iss_dr1, iss_dr2;
    logic [CELL_AW-1:0]  iss_addr_a, iss_addr_b;
    logic [SCORE_AW-1:0] iss_addr_s;
    logic [LOAD_W-1:0]   w_prod_a, w_prod_b;

    // use side
    logic             use_dr1, use_dr2;
    t_merge_ctl       w_mctl;
    t_score           w_merged;
    logic             w_cell_ok;
    logic [CH_SUM_W-1:0] w_ch;
    t_score           w_res;
    logic             w_wr;

    assign w_last    = T_W'(({1'b0, i_side} << 1) - (SIDE_W + 1)'(2));
    assign w_end_r2  = ({1'b0, r_r2} == i_side - SIDE_W'(1));
    assign w_end_r1  = ({1'b0, r_r1} == i_side - SIDE_W'(1));
    assign w_end_all = w_end_r1 && w_end_r2 && (r_t == '0);

    // Advance row pair, then anti-diagonal downward
    always_comb begin
        n_t  = r_t;
        n_r1 = r_r1;
        n_r2 = r_r2;
        if (w_end_r2) begin
            n_r2 = '0;
            if (w_end_r1) begin
                n_r1 = '0;
                n_t  = r_t - T_W'(1);
            end else begin
                n_r1 = r_r1 + IDX_W'(1);
            end
        end else begin
            n_r2 = r_r2 + IDX_W'(1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_go) n_state = S_PRIME;
            S_PRIME: n_state = S_RUN;
            S_RUN:   if (r_phase == 2'd3 && w_end_all) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  o_busy  = 1'b0;
            S_DONE:  o_valid = 1'b1;
            default: o_valid = 1'b0;
        endcase
    end

    assign o_found = r_top.vld;
    assign o_total = r_top.vld ? r_top.val[TOTAL_W-1:0] : '0;

    // Pick what to read next: the current pair's next candidate,
    // or the next pair's cells and first candidate (in S_PRIME, the first pair's)
    always_comb begin
        iss_t     = r_t;
        iss_r1    = r_r1;
        iss_r2    = r_r2;
        iss_k     = r_phase + 2'd1;
        iss_cells = 1'b0;
        iss_score = 1'b0;
        if (r_state == S_PRIME) begin
            iss_k     = 2'd0;
            iss_cells = 1'b1;
            iss_score = 1'b1;
        end else if (r_state == S_RUN) begin
            iss_score = 1'b1;
            if (r_phase == 2'd3) begin
                iss_t     = n_t;
                iss_r1    = n_r1;
                iss_r2    = n_r2;
                iss_cells = 1'b1;
            end
        end
    end

    // Candidate offsets: both down, none, first down, second down
    assign iss_dr1 = (iss_k == 2'd0) || (iss_k == 2'd2);
    assign iss_dr2 = (iss_k == 2'd0) || (iss_k == 2'd3);
    assign iss_addr_s = {~iss_t[0], iss_r1 + IDX_W'(iss_dr1), iss_r2 + IDX_W'(iss_dr2)};

    // Raster address row * side + column, column = diagonal - row
    assign w_prod_a   = LOAD_W'(iss_r1) * LOAD_W'(i_side);
    assign w_prod_b   = LOAD_W'(iss_r2) * LOAD_W'(i_side);
    assign iss_addr_a = CELL_AW'(w_prod_a + LOAD_W'(iss_t - T_W'(iss_r1)));
    assign iss_addr_b = CELL_AW'(w_prod_b + LOAD_W'(iss_t - T_W'(iss_r2)));

    // Cell store: load write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_load_we) begin
            mem_cell[i_load_addr] <= i_load_data;
        end
        if (iss_cells) begin
            r_cell_a <= mem_cell[iss_addr_a];
            r_cell_b <= mem_cell[iss_addr_b];
        end
    end

    // Score store: one write port, one registered read port;
    // forward a score that is written at the same edge it is read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_score[{r_t[0], r_r1, r_r2}] <= w_res;
        end
        if (iss_score) begin
            if (w_wr && (iss_addr_s == {r_t[0], r_r1, r_r2})) begin
                r_rd_score <= w_res;
            end else begin
                r_rd_score <= mem_score[iss_addr_s];
            end
        end
    end

    // Candidate being folded this cycle must lie inside the grid
    assign use_dr1 = (r_phase == 2'd0) || (r_phase == 2'd2);
    assign use_dr2 = (r_phase == 2'd0) || (r_phase == 2'd3);
    always_comb begin
        w_mctl.clear    = (r_phase == 2'd0);
        w_mctl.use_cand = (({1'b0, r_r1} + SIDE_W'(use_dr1)) < i_side) &&
                          (({1'b0, r_r2} + SIDE_W'(use_dr2)) < i_side);
    end

    gtp_merge u_merge (
        .i_ctl  (w_mctl),
        .i_acc  (r_acc),
        .i_cand (r_rd_score),
        .o_acc  (w_merged)
    );

    // Both cells on the grid (passability goes into r_pass); sum cherries, shared cell once
    assign w_cell_ok = ({1'b0, r_r1} <= r_t) && ({1'b0, r_r2} <= r_t) &&
                       ((r_t - T_W'(r_r1)) < i_side) && ((r_t - T_W'(r_r2)) < i_side);
    assign w_ch = CH_SUM_W'(r_cell_a.ch) +
                  ((r_r1 != r_r2) ? CH_SUM_W'(r_cell_b.ch) : CH_SUM_W'(0));

    // Score of the current pair after the last candidate
    always_comb begin
        w_res = '0;
        if (r_pass) begin
            if (r_t == w_last) begin
                w_res.vld = 1'b1;
                w_res.val = SCORE_W'(r_ch);
            end else if (w_merged.vld) begin
                w_res.vld = 1'b1;
                w_res.val = w_merged.val + SCORE_W'(r_ch);
            end
        end
    end
    assign w_wr = (r_state == S_RUN) && (r_phase == 2'd3);

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_phase <= r_phase + 2'd1;
            end else begin
                r_phase <= 2'd0;
            end
        end
    end

    // Indexes, accumulator and result hold
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_go) begin
            r_t  <= w_last;
            r_r1 <= '0;
            r_r2 <= '0;
        end
        if (r_state == S_RUN) begin
            r_acc <= w_merged;
            if (r_phase == 2'd0) begin
                r_pass <= w_cell_ok && !r_cell_a.blk && !r_cell_b.blk;
                r_ch   <= w_ch;
            end
            if (r_phase == 2'd3) begin
                r_t  <= n_t;
                r_r1 <= n_r1;
                r_r2 <= n_r2;
                if (r_t == '0 && r_r1 == '0 && r_r2 == '0) begin
                    r_top <= w_res;
                end
            end
        end
    end

endmodule
